[rtl/lpr_pkg.sv]
// Package for the LRU page replacement block: field widths, the sequencer
// state type and the control word that drives the row of recency cells.
// No dependencies.
package lpr_pkg;

  // Field widths fixed by the stream words
  localparam int unsigned PAGE_IN_W  = 16;
  localparam int unsigned EV_PAGE_W  = 16;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned OUT_DATA_W = EV_PAGE_W + 2 * TOTAL_W;
  localparam int unsigned OUT_USER_W = 2;

  // Reset value of the frame count register
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // Control word broadcast to every cell
  typedef struct packed {
    logic compare;  // register the per-cell tag match
    logic update;   // apply the recency update this cycle
    logic hit;      // reference found: move it to the most recent slot
    logic evict;    // miss with all frames used: drop slot 0 and append
    logic fill;     // miss with a free frame: append in the first free slot
  } cell_ctrl_t;

endpackage

[rtl/lpr_cell.sv]
// One recency slot of the LRU row: page tag, valid bit and match flag.
// Takes its neighbours' page and valid; depends on lpr_pkg.
module lpr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpr_pkg::cell_ctrl_t   ctrl,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic                  prev_valid,
  input  logic [PAGE_BITS-1:0]  next_page,
  input  logic                  next_valid,
  input  logic                  seen_in,
  output logic [PAGE_BITS-1:0]  page,
  output logic                  valid,
  output logic                  seen_out
);
  import lpr_pkg::*;

  logic match;
  logic last;

  // A match at or below this slot means this slot takes part in the shift
  assign seen_out = seen_in | match;
  // Most recent occupied slot
  assign last     = valid & ~next_valid;

  // Tag compare, registered
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= valid && (page == in_page);
    end
  end

  // Valid bit: set only when a free slot is filled
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.update && ctrl.fill && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  // Page tag: shift towards slot 0, or take the new reference
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (ctrl.hit || ctrl.evict) begin
        if (last) begin
          page <= in_page;
        end else if (valid && (ctrl.evict || seen_out)) begin
          page <= next_page;
        end
      end else if (ctrl.fill && !valid && prev_valid) begin
        page <= in_page;
      end
    end
  end

endmodule

[rtl/lru_page_replacement_top.sv]
// Top level of the LRU page replacement block: sequencer, frame count
// register, totals, output register and the row of lpr_cell slots.
// Depends on lpr_pkg and lpr_cell.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one page reference per word.
//   m_tvalid/m_tready/m_tdata/m_tuser return one result word per reference:
//   hit or fault, the evicted page if any, and saturating fault and hit
//   totals counted since reset.
//   cfg_we/cfg_wdata write the number of frames in use (0 acts as 1, values
//   above FRAMES act as FRAMES); write it only while the block is idle.
// Sequence:
//   A reference is accepted in ST_IDLE, every slot compares its tag in
//   ST_MATCH (registered match), and the row shifts in ST_UPDATE, loading
//   the output register. The block takes one reference at a time and takes
//   no new one until the update step has been done. The next reference may
//   be accepted while a result is waiting.
// Reset: all slots empty, totals zero, frame count 16, no result pending.
// Stall: with a result still held in the output register, the update step
//   waits; s_tready stays low until that update has been done.
module lru_page_replacement_top #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lpr_pkg::PAGE_IN_W-1:0]     s_tdata,   // [15:0] page_number
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] evicted_page, [47:16] fault_total, [79:48] hit_total
  output logic [lpr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [lpr_pkg::OUT_USER_W-1:0]    m_tuser,   // [0] hit, [1] evicted_valid
  input  logic                              cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]         cfg_wdata
);
  import lpr_pkg::*;

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [7:0]  FRAMES_B = 8'(FRAMES);

  state_t                state, state_next;
  cell_ctrl_t            ctrl;
  logic [CFG_W-1:0]      active_frames;
  logic [PAGE_BITS-1:0]  ref_page;
  logic                  full;
  logic [TOTAL_W-1:0]    fault_total, hit_total;
  logic [TOTAL_W-1:0]    fault_total_next, hit_total_next;
  logic                  out_free;
  logic                  found;

  logic [PAGE_BITS-1:0]  cell_page  [FRAMES];
  logic [FRAMES-1:0]     cell_valid;
  logic [FRAMES:0]       seen;

  logic [31:0]           in_wide, ev_wide;
  logic [7:0]            af_ext, lim;
  logic [IDX_W-1:0]      lim_idx;

  // Frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= FRAMES_RESET;
    end else if (cfg_we) begin
      active_frames <= cfg_wdata;
    end
  end

  // Clamp the frame count to 1..FRAMES and index its last slot
  always_comb begin
    af_ext = 8'(active_frames);
    if (af_ext == 8'd0) begin
      lim = 8'd0;
    end else if (af_ext > FRAMES_B) begin
      lim = FRAMES_B - 8'd1;
    end else begin
      lim = af_ext - 8'd1;
    end
    lim_idx = lim[IDX_W-1:0];
  end

  // Reference page masked to the stored width
  assign in_wide = 32'(s_tdata);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ref_page <= in_wide[PAGE_BITS-1:0];
    end
  end

  // Occupancy check, taken with the tag compare
  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      full <= cell_valid[lim_idx];
    end
  end

  // Sequencer: next state
  assign out_free = ~m_tvalid | m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: outputs
  assign found = seen[FRAMES];

  always_comb begin
    s_tready     = (state == ST_IDLE);
    ctrl.compare = (state == ST_MATCH);
    ctrl.update  = (state == ST_UPDATE) && out_free;
    ctrl.hit     = found;
    ctrl.evict   = ~found & full;
    ctrl.fill    = ~found & ~full;
  end

  // Row of recency slots, slot 0 least recent
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] nxt_page;
    logic                 nxt_valid;
    logic                 prv_valid;

    if (i == FRAMES - 1) begin : g_end
      assign nxt_page  = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_mid
      assign nxt_page  = cell_page[i+1];
      assign nxt_valid = cell_valid[i+1];
    end

    if (i == 0) begin : g_first
      assign prv_valid = 1'b1;
    end else begin : g_rest
      assign prv_valid = cell_valid[i-1];
    end

    lpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_page    (ref_page),
      .prev_valid (prv_valid),
      .next_page  (nxt_page),
      .next_valid (nxt_valid),
      .seen_in    (seen[i]),
      .page       (cell_page[i]),
      .valid      (cell_valid[i]),
      .seen_out   (seen[i+1])
    );
  end

  // Saturating totals
  always_comb begin
    fault_total_next = fault_total;
    hit_total_next   = hit_total;
    if (found) begin
      if (hit_total != '1) hit_total_next = hit_total + 32'd1;
    end else begin
      if (fault_total != '1) fault_total_next = fault_total + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_total <= '0;
      hit_total   <= '0;
    end else if (ctrl.update) begin
      fault_total <= fault_total_next;
      hit_total   <= hit_total_next;
    end
  end

  // Output register
  assign ev_wide = 32'(cell_page[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      m_tuser <= {ctrl.evict, found};
      m_tdata <= {hit_total_next, fault_total_next,
                  ctrl.evict ? ev_wide[EV_PAGE_W-1:0] : EV_PAGE_W'(0)};
    end
  end

endmodule

[rtl/lpr_checker.sv]
// Port-level checks for the LRU page replacement block, bound to the top.
// Depends on lpr_pkg and lru_page_replacement_top.
module lpr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lpr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [lpr_pkg::OUT_USER_W-1:0] m_tuser
);
  import lpr_pkg::*;

  // Only one reference in flight: ready drops after an accepted word
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a reference is in flight");

  // A result never shows up in the cycle after its reference is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result earlier than the compare step allows");

  // A hit never evicts, and no eviction means a zero page
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit reported together with an eviction");

  a_ev_page_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[EV_PAGE_W-1:0] == '0))
    else $error("evicted page not zero without an eviction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result word changed while stalled");

endmodule

bind lru_page_replacement_top lpr_checker u_lpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[dv/tb_top.sv]
// Self-checking bench for lru_page_replacement_top: page references go in on the
// slave stream, and every result word is checked against an LRU recency-list predictor.
// Depends on lpr_pkg and the RTL of lru_page_replacement_top.
`timescale 1ns / 100ps

module tb_top;
  import lpr_pkg::*;

  localparam int unsigned FRAME_SLOTS = 16;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;

  // Expected content of one result word
  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
    logic [31:0] hit_total;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PAGE_IN_W-1:0]   s_tdata = '0;   // [15:0] page_number
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [15:0] evicted_page, [47:16] fault_total, [79:48] hit_total
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;        // [0] hit, [1] evicted_valid
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Stimulus and prediction state
  logic [15:0]    pages_to_send[$];
  logic [15:0]    recency_list[$];        // least recent first
  lookup_result_t expected_results[$];
  logic [CFG_W-1:0] frames_setting = FRAMES_RESET;
  logic [31:0]    fault_count = '0;
  logic [31:0]    hit_count = '0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_request = 1'b0;
  bit             hold_taken = 1'b0;
  int             hold_left = 0;
  int             mismatches = 0;
  int unsigned    quiet_cycles = 0;

  lru_page_replacement_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Frames in effect: zero acts as one, anything above the slot count is clamped
  function automatic int frames_in_use();
    int lim;
    lim = int'(frames_setting);
    if (lim < 1) lim = 1;
    if (lim > FRAME_SLOTS) lim = FRAME_SLOTS;
    return lim;
  endfunction

  // LRU update for one reference; queues the result word it should produce
  function automatic void predict_reference(logic [15:0] page);
    int             found;
    lookup_result_t res;
    found = -1;
    res = '0;
    foreach (recency_list[i]) begin
      if (found < 0 && recency_list[i] == page) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      recency_list.delete(found);
      recency_list.insert(recency_list.size(), page);
      if (hit_count != 32'hFFFF_FFFF) hit_count++;
    end else begin
      // a lowered frame count never grows the list, one out for one in
      if (recency_list.size() >= frames_in_use()) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = recency_list.pop_front();
      end
      recency_list.insert(recency_list.size(), page);
      if (fault_count != 32'hFFFF_FFFF) fault_count++;
    end
    res.fault_total = fault_count;
    res.hit_total   = hit_count;
    expected_results.insert(expected_results.size(), res);
  endfunction

  // Mostly a small working set around base so that hits and evictions both occur
  function automatic logic [15:0] pick_page(logic [15:0] base, int span);
    if ($urandom_range(99) < 75) return base + 16'($urandom_range(span));
    return 16'($urandom);
  endfunction

  // Driver: offers queued pages, records each accepted word with the predictor
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_reference(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pages_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pages_to_send.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: checks each result word, drives m_tready with random and long stalls
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, actual tuser %0h tdata %0h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(m_tuser[1]));
          check_field("evicted_page", 32'(want.evicted_page), 32'(m_tdata[15:0]));
          check_field("fault_total", want.fault_total, m_tdata[47:16]);
          check_field("hit_total", want.hit_total, m_tdata[79:48]);
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pages_to_send.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_setting = value;
  endtask

  // One phase: frame count, idling mix, then random references around base
  task automatic run_phase(logic [CFG_W-1:0] frames, int count, int s_pct, int r_pct,
                           logic [15:0] base, int span);
    write_frames(frames);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) pages_to_send.insert(pages_to_send.size(), pick_page(base, span));
  endtask

  initial begin
    logic [15:0] shared_base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme pages, hits, fill to all 16 frames, then evictions
    send_idle_pct = 20;
    recv_idle_pct = 48;
    pages_to_send = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h5555, 16'hAAAA,
                      16'h0001};
    for (int p = 16'h0010; p < 16'h001C; p++)
      pages_to_send.insert(pages_to_send.size(), 16'(p));
    pages_to_send.insert(pages_to_send.size(), 16'h1234);   // full: LRU page goes
    pages_to_send.insert(pages_to_send.size(), 16'hFFFF);   // evicted earlier, misses again
    pages_to_send.insert(pages_to_send.size(), 16'h0001);   // hit on the second least recent page
    wait_drained();

    // Single frame, then zero which acts as one
    run_phase(5'd1, 60, 20, 48, 16'($urandom), 3);
    wait_drained();
    run_phase(5'd0, 30, 20, 48, 16'($urandom), 2);
    wait_drained();

    // Oversized count acts as all frames; then lower below occupancy, same pages
    shared_base = 16'($urandom);
    run_phase(5'd31, 100, 48, 20, shared_base, 19);
    wait_drained();
    run_phase(5'd4, 60, 48, 20, shared_base, 19);
    wait_drained();

    // No idling; a long receiver hold fills the block and stalls its input
    run_phase(5'd16, 100, 0, 0, 16'($urandom), 20);
    hold_request = 1'b1;
    wait_drained();
    run_phase(5'($urandom_range(15, 2)), 80, 0, 0, 16'($urandom), 12);
    wait_drained();
    run_phase(5'd17, 70, 0, 0, 16'($urandom), 22);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[lru_page_replacement_top.f]
rtl/lpr_pkg.sv
rtl/lpr_cell.sv
rtl/lru_page_replacement_top.sv
rtl/lpr_checker.sv
dv/tb_top.sv
